[hw/rtl/grid_line_interpolator_assert.svh]
// Assertion macros used by the grid line interpolator top level.
`ifndef GRID_LINE_INTERPOLATOR_ASSERT_SVH
`define GRID_LINE_INTERPOLATOR_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define GLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define GLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gli_pkg.sv]
// Types, codes and constants of the grid line interpolator.
package gli_pkg;

  localparam int VALUE_W   = 24;
  localparam int SNAP_W    = 36;
  localparam int DIV_DVD_W = 48;
  localparam int DIV_DVS_W = 45;
  localparam int CFG_IDX_W = 3;

  localparam logic [13:0] SNAP_SCALE = 14'd10000;
  localparam logic [12:0] SNAP_BIAS  = 13'd4999;
  localparam logic signed [14:0] SNAP_SCALE_S = 15'sd10000;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_BUILD = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DROP  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_ORIGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 3'd5;

  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_CLR   = 5'd2;
  localparam logic [4:0] OP_PMUL  = 5'd3;
  localparam logic [4:0] OP_PADD  = 5'd4;
  localparam logic [4:0] OP_PDIV  = 5'd5;
  localparam logic [4:0] OP_PSAVE = 5'd6;
  localparam logic [4:0] OP_PCOM  = 5'd7;
  localparam logic [4:0] OP_RD    = 5'd8;
  localparam logic [4:0] OP_RDAT  = 5'd9;
  localparam logic [4:0] OP_BCHK  = 5'd10;
  localparam logic [4:0] OP_BLO   = 5'd11;
  localparam logic [4:0] OP_LEAD  = 5'd12;
  localparam logic [4:0] OP_SRD   = 5'd13;
  localparam logic [4:0] OP_SCHK  = 5'd14;
  localparam logic [4:0] OP_GDIV  = 5'd15;
  localparam logic [4:0] OP_GSET  = 5'd16;
  localparam logic [4:0] OP_FILL  = 5'd17;
  localparam logic [4:0] OP_TAIL  = 5'd18;
  localparam logic [4:0] OP_OUT   = 5'd19;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [23:0] sample_value;
    logic        sample_set;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] single_origin;
    logic [30:0]        single_step;
    logic signed [31:0] sort_origin;
    logic [30:0]        sort_step;
    logic [15:0]        slot_offset;
    logic [10:0]        line_length;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic       axis_x;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic bld_bad;
    logic cnt_eq_first;
    logic cnt_ge_n;
    logic is_point;
    logic j_eq_cnt;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/grid_line_interpolator.sv]
// Grid line interpolator top level: configuration registers, sequencer and datapath.
//
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall; each
// accepted item gives exactly one result item. Configuration registers are written
// over cfg_valid/cfg_ready/cfg_index/cfg_data; the user writes them only while the
// block is idle, which the block does not enforce itself; cfg_ready is always high.
// One item is worked on at a time; in_stall stays high until its result sits in the
// output register, so a new item can enter while that result waits for the receiver.
// An added point takes two divisions in the shared divider, one per axis; a clear
// sweeps the line memory. A build walks the line memory slot by slot and runs the
// divider once per gap between points. After reset the line memory is swept with
// in_stall high.
// A stalled result holds in the output register and blocks the next result.
`include "grid_line_interpolator_assert.svh"

module grid_line_interpolator #(
  parameter int LINE_DEPTH      = 1024,
  parameter int VALUE_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gli_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gli_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gli_pkg::out_item_t               out_item
);
  import gli_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  cmd_t  cmd;
  stat_t st;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SINGLE_ORIGIN: cfg_nxt.single_origin = cfg_data;
        CFG_SINGLE_STEP:   cfg_nxt.single_step   = cfg_data[30:0];
        CFG_SORT_ORIGIN:   cfg_nxt.sort_origin   = cfg_data;
        CFG_SORT_STEP:     cfg_nxt.sort_step     = cfg_data[30:0];
        CFG_SLOT_OFFSET:   cfg_nxt.slot_offset   = cfg_data[15:0];
        CFG_LINE_LENGTH:   cfg_nxt.line_length   = cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.single_origin <= '0;
      cfg_r.single_step   <= 31'd65536;
      cfg_r.sort_origin   <= '0;
      cfg_r.sort_step     <= 31'd65536;
      cfg_r.slot_offset   <= '0;
      cfg_r.line_length   <= 11'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  gli_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .func(in_item.func),
    .st(st), .cmd(cmd), .in_stall(in_stall)
  );

  gli_dp #(.LINE_DEPTH(LINE_DEPTH), .VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_item(in_item), .cmd(cmd), .st(st),
    .out_stall(out_stall), .out_valid(out_valid), .out_item(out_item)
  );

  `GLI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy not raised after item")
  `GLI_ASSERT_NOW(a_result_while_busy, $rose(out_valid), $past(in_stall), "result without busy item")

endmodule

[hw/rtl/gli_ram.sv]
// Generic simple dual-port RAM with registered read.
module gli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/gli_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module gli_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gli_pkg::DIV_DVD_W-1:0]  dividend,
  input  logic [gli_pkg::DIV_DVS_W-1:0]  divisor,
  output logic                           done,
  output logic [gli_pkg::DIV_DVD_W-1:0]  quotient,
  output logic [gli_pkg::DIV_DVS_W-1:0]  remainder
);
  import gli_pkg::*;

  localparam int CW = $clog2(DIV_DVD_W + 1);

  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic [DIV_DVS_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [DIV_DVD_W-1:0] quo_r, quo_nxt;
  logic [DIV_DVS_W:0]   sh;
  logic                 ge;

  always_comb begin
    sh      = {rem_r, quo_r[DIV_DVD_W-1]};
    ge      = sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DIV_DVS_W'(sh - {1'b0, dvs_r}) : sh[DIV_DVS_W-1:0];
    quo_nxt = {quo_r[DIV_DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DIV_DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/gli_ctrl.sv]
// Sequencer of the grid line interpolator: one command per cycle to the datapath.
module gli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     func,
  input  gli_pkg::stat_t st,
  output gli_pkg::cmd_t  cmd,
  output logic           in_stall
);
  import gli_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_PMUL  = 5'd3;
  localparam logic [4:0] S_PADD  = 5'd4;
  localparam logic [4:0] S_PDIV  = 5'd5;
  localparam logic [4:0] S_PWAIT = 5'd6;
  localparam logic [4:0] S_PSAVE = 5'd7;
  localparam logic [4:0] S_PCOM  = 5'd8;
  localparam logic [4:0] S_RD    = 5'd9;
  localparam logic [4:0] S_RDAT  = 5'd10;
  localparam logic [4:0] S_BCHK  = 5'd11;
  localparam logic [4:0] S_BLO   = 5'd12;
  localparam logic [4:0] S_LEAD  = 5'd13;
  localparam logic [4:0] S_SRD   = 5'd14;
  localparam logic [4:0] S_SCHK  = 5'd15;
  localparam logic [4:0] S_GDIV  = 5'd16;
  localparam logic [4:0] S_GWAIT = 5'd17;
  localparam logic [4:0] S_GSET  = 5'd18;
  localparam logic [4:0] S_FILL  = 5'd19;
  localparam logic [4:0] S_TAIL  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic       ax_r, ax_nxt;

  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    cmd.op     = OP_NOP;
    cmd.axis_x = ax_r;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          ax_nxt = 1'b0;
          unique case (func)
            FUNC_CLEAR: state_nxt = S_CLR;
            FUNC_ADD:   state_nxt = S_PMUL;
            FUNC_BUILD: state_nxt = S_BCHK;
            FUNC_READ:  state_nxt = S_RD;
          endcase
        end
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_nxt = S_DONE;
      end
      S_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = S_PADD;
      end
      S_PADD: begin
        cmd.op    = OP_PADD;
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        cmd.op    = OP_PDIV;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (st.div_done) state_nxt = S_PSAVE;
      end
      S_PSAVE: begin
        cmd.op = OP_PSAVE;
        if (ax_r) begin
          state_nxt = S_PCOM;
        end else begin
          ax_nxt    = 1'b1;
          state_nxt = S_PMUL;
        end
      end
      S_PCOM: begin
        cmd.op    = OP_PCOM;
        state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_RDAT;
      end
      S_RDAT: begin
        cmd.op    = OP_RDAT;
        state_nxt = S_DONE;
      end
      S_BCHK: begin
        cmd.op    = OP_BCHK;
        state_nxt = st.bld_bad ? S_DONE : S_BLO;
      end
      S_BLO: begin
        cmd.op    = OP_BLO;
        state_nxt = S_LEAD;
      end
      S_LEAD: begin
        cmd.op = OP_LEAD;
        if (st.cnt_eq_first) state_nxt = S_SRD;
      end
      S_SRD: begin
        cmd.op    = OP_SRD;
        state_nxt = st.cnt_ge_n ? S_TAIL : S_SCHK;
      end
      S_SCHK: begin
        cmd.op    = OP_SCHK;
        state_nxt = st.is_point ? S_GDIV : S_SRD;
      end
      S_GDIV: begin
        cmd.op    = OP_GDIV;
        state_nxt = S_GWAIT;
      end
      S_GWAIT: begin
        if (st.div_done) state_nxt = S_GSET;
      end
      S_GSET: begin
        cmd.op    = OP_GSET;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (st.j_eq_cnt) state_nxt = S_SRD;
      end
      S_TAIL: begin
        cmd.op = OP_TAIL;
        if (st.cnt_ge_n) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ax_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[hw/rtl/gli_dp.sv]
// Datapath of the grid line interpolator: line memory, snapping, gap fill and result register.
module gli_dp #(
  parameter int LINE_DEPTH      = 1024,
  parameter int VALUE_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gli_pkg::cfg_t      cfg,
  input  gli_pkg::in_item_t  in_item,
  input  gli_pkg::cmd_t      cmd,
  output gli_pkg::stat_t     st,
  input  logic               out_stall,
  output logic               out_valid,
  output gli_pkg::out_item_t out_item
);
  import gli_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int MW = VALUE_W + 1;

  in_item_t  item_r, item_nxt;
  out_item_t res_r, res_nxt, out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic [LW-1:0] cnt_r, cnt_nxt, j_r, j_nxt, n;
  logic [AW-1:0] first_r, first_nxt, last_r, last_nxt;
  logic [AW-1:0] beg_r, beg_nxt, hlim_r, hlim_nxt;
  logic          any_r, any_nxt;

  logic [VALUE_W-1:0]      a_r, a_nxt, b_r, b_nxt, q_r, q_nxt;
  logic [AW-1:0]           g_r, g_nxt, r_r, r_nxt, dr_r, dr_nxt;
  logic signed [VALUE_W+1:0] dq_r, dq_nxt, qs;
  logic                    dneg_r, dneg_nxt;
  logic [AW:0]             r2;
  logic                    carry;

  logic signed [31:0]      coord, origin;
  logic [30:0]             step;
  logic signed [32:0]      diff;
  logic signed [47:0]      m1_r, m1_nxt, num_r, num_nxt;
  logic [43:0]             m2_r, m2_nxt;
  logic [44:0]             den_r, den_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [SNAP_W-1:0] sy_r, sy_nxt, sx_r, sx_nxt, snapped;
  logic signed [SNAP_W:0]  slot;
  logic                    drop;
  logic [15:0]             idx;
  logic [AW-1:0]           s;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;

  logic                 div_start, div_done;
  logic [DIV_DVD_W-1:0] dvd, quo;
  logic [DIV_DVS_W-1:0] dvs, rem;

  gli_ram #(.WIDTH(MW), .DEPTH(LINE_DEPTH)) u_line (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  gli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    if (32'(cfg.line_length) < 32'(LINE_DEPTH)) begin
      n = LW'(cfg.line_length);
    end else begin
      n = LW'(LINE_DEPTH);
    end
  end

  always_comb begin
    coord   = cmd.axis_x ? item_r.point_x : item_r.point_y;
    origin  = cmd.axis_x ? cfg.sort_origin : cfg.single_origin;
    step    = cmd.axis_x ? cfg.sort_step : cfg.single_step;
    if (step == '0) step = 31'd1;
    diff    = $signed({coord[31], coord}) - $signed({origin[31], origin});
    snapped = neg_r ? -$signed(SNAP_W'(quo)) : $signed(SNAP_W'(quo));
    slot    = $signed({sy_r[SNAP_W-1], sy_r})
              - $signed((SNAP_W+1)'(cfg.slot_offset));
    drop    = (slot < 0) || (slot >= $signed((SNAP_W+1)'(n)));
    s       = slot[AW-1:0];
    if (sx_r < 0) begin
      idx = 16'd0;
    end else if (sx_r > $signed(SNAP_W'(65535))) begin
      idx = 16'hFFFF;
    end else begin
      idx = sx_r[15:0];
    end
    r2    = {1'b0, r_r} + {1'b0, dr_r};
    carry = r2 >= {1'b0, g_r};
    qs    = $signed({2'b00, q_r}) + dq_r + $signed((VALUE_W+2)'(carry));
  end

  always_comb begin
    st.clr_last     = cnt_r == LW'(LINE_DEPTH - 1);
    st.div_done     = div_done;
    st.bld_bad      = !any_r || (LW'(first_r) >= n);
    st.cnt_eq_first = cnt_r == LW'(first_r);
    st.cnt_ge_n     = cnt_r >= n;
    st.is_point     = rdata[VALUE_W] && (cnt_r <= LW'(hlim_r));
    st.j_eq_cnt     = j_r == cnt_r;
    st.out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    any_nxt   = any_r;
    beg_nxt   = beg_r;
    hlim_nxt  = hlim_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    q_nxt     = q_r;
    g_nxt     = g_r;
    r_nxt     = r_r;
    dr_nxt    = dr_r;
    dq_nxt    = dq_r;
    dneg_nxt  = dneg_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    sy_nxt    = sy_r;
    sx_nxt    = sx_r;
    we        = 1'b0;
    waddr     = AW'(cnt_r);
    wdata     = {1'b1, a_r};
    raddr     = AW'(cnt_r);
    div_start = 1'b0;
    dvd       = num_r[47] ? DIV_DVD_W'(-num_r) : DIV_DVD_W'(num_r);
    dvs       = den_r;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        item_nxt = in_item;
        res_nxt  = '0;
        cnt_nxt  = '0;
      end
      OP_CLR: begin
        we        = 1'b1;
        wdata     = '0;
        cnt_nxt   = cnt_r + 1'b1;
        first_nxt = AW'(LINE_DEPTH - 1);
        last_nxt  = '0;
        any_nxt   = 1'b0;
      end
      OP_PMUL: begin
        m1_nxt  = diff * SNAP_SCALE_S;
        m2_nxt  = step * SNAP_BIAS;
        den_nxt = step * SNAP_SCALE;
      end
      OP_PADD: begin
        num_nxt = m1_r + $signed(48'(m2_r));
      end
      OP_PDIV: begin
        div_start = 1'b1;
        neg_nxt   = num_r[47];
      end
      OP_PSAVE: begin
        if (cmd.axis_x) begin
          sx_nxt = snapped;
        end else begin
          sy_nxt = snapped;
        end
      end
      OP_PCOM: begin
        if (drop) begin
          res_nxt.status = STATUS_DROP;
        end else begin
          we    = 1'b1;
          waddr = s;
          wdata = {1'b1, VALUE_W'(32'(idx) << VALUE_FRAC_BITS)};
          if (!any_r || s < first_r) first_nxt = s;
          if (!any_r || s > last_r) last_nxt = s;
          any_nxt = 1'b1;
        end
      end
      OP_RD: begin
        raddr = AW'(item_r.read_index);
      end
      OP_RDAT: begin
        if (32'(item_r.read_index) < 32'(LINE_DEPTH) && rdata[VALUE_W]) begin
          res_nxt.sample_value = rdata[VALUE_W-1:0];
          res_nxt.sample_set   = 1'b1;
        end
      end
      OP_BCHK: begin
        raddr   = first_r;
        cnt_nxt = '0;
        if (st.bld_bad) begin
          res_nxt.status = STATUS_EMPTY;
        end else if (LW'(last_r) < n) begin
          hlim_nxt = last_r;
        end else begin
          hlim_nxt = AW'(n - 1'b1);
        end
      end
      OP_BLO: begin
        a_nxt   = rdata[VALUE_W-1:0];
        beg_nxt = first_r;
      end
      OP_LEAD: begin
        if (st.cnt_eq_first) begin
          cnt_nxt = LW'(first_r) + 1'b1;
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_SRD: begin
        if (st.cnt_ge_n) cnt_nxt = LW'(beg_r) + 1'b1;
      end
      OP_SCHK: begin
        b_nxt = rdata[VALUE_W-1:0];
        g_nxt = AW'(cnt_r) - beg_r;
        if (!st.is_point) cnt_nxt = cnt_r + 1'b1;
      end
      OP_GDIV: begin
        div_start = 1'b1;
        dneg_nxt  = b_r < a_r;
        dvd       = (b_r < a_r) ? DIV_DVD_W'(a_r - b_r) : DIV_DVD_W'(b_r - a_r);
        dvs       = DIV_DVS_W'(g_r);
      end
      OP_GSET: begin
        q_nxt = a_r;
        r_nxt = g_r >> 1;
        j_nxt = LW'(beg_r) + 1'b1;
        if (dneg_r && rem[AW-1:0] != '0) begin
          dq_nxt = -$signed({2'b00, quo[VALUE_W-1:0]}) - $signed((VALUE_W+2)'(1));
          dr_nxt = g_r - rem[AW-1:0];
        end else if (dneg_r) begin
          dq_nxt = -$signed({2'b00, quo[VALUE_W-1:0]});
          dr_nxt = '0;
        end else begin
          dq_nxt = $signed({2'b00, quo[VALUE_W-1:0]});
          dr_nxt = rem[AW-1:0];
        end
      end
      OP_FILL: begin
        if (st.j_eq_cnt) begin
          beg_nxt = AW'(cnt_r);
          a_nxt   = b_r;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          we     = 1'b1;
          waddr  = AW'(j_r);
          wdata  = {1'b1, qs[VALUE_W-1:0]};
          q_nxt  = qs[VALUE_W-1:0];
          r_nxt  = carry ? AW'(r2 - {1'b0, g_r}) : r2[AW-1:0];
          j_nxt  = j_r + 1'b1;
        end
      end
      OP_TAIL: begin
        if (st.cnt_ge_n) begin
          first_nxt = '0;
          last_nxt  = AW'(n - 1'b1);
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_OUT: begin
        out_nxt       = res_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      first_r     <= AW'(LINE_DEPTH - 1);
      last_r      <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    j_r    <= j_nxt;
    beg_r  <= beg_nxt;
    hlim_r <= hlim_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    q_r    <= q_nxt;
    g_r    <= g_nxt;
    r_r    <= r_nxt;
    dr_r   <= dr_nxt;
    dq_r   <= dq_nxt;
    dneg_r <= dneg_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    sy_r   <= sy_nxt;
    sx_r   <= sx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[tb/tb.sv]
// Self-checking testbench for grid_line_interpolator: random and directed items against a predictor.
`timescale 1ns / 1ps

module tb;
  import gli_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  grid_line_interpolator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  localparam int DEPTH = 1024;
  localparam int FRAC = 8;

  always #5 clk = ~clk;

  // Predicted line state and register copy.
  logic [23:0] line_val [DEPTH];
  bit line_set [DEPTH];
  int unsigned first_pt, last_pt;
  bit have_point;
  cfg_t regs;

  out_item_t pending_samples[$];
  int mismatches = 0;
  int sent_items = 0;
  int n_points = 0, n_builds = 0, n_reads = 0, n_drops = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;

  function automatic longint snap_coord(logic [31:0] c, logic [31:0] o, logic [30:0] st);
    longint s;
    longint num;
    s = (st == 0) ? 64'sd1 : longint'({33'b0, st});
    num = (longint'($signed(c)) - longint'($signed(o))) * 10000 + 4999 * s;
    return num / (10000 * s);
  endfunction

  function automatic int unsigned usable_len();
    return (regs.line_length > DEPTH) ? DEPTH : regs.line_length;
  endfunction

  function automatic void line_clear();
    foreach (line_set[i]) line_set[i] = 1'b0;
    first_pt = DEPTH - 1;
    last_pt = 0;
    have_point = 1'b0;
  endfunction

  function automatic logic [1:0] line_add_point(logic [31:0] px, logic [31:0] py);
    longint slot;
    longint idx;
    int unsigned s;
    slot = snap_coord(py, regs.single_origin, regs.single_step) - longint'(regs.slot_offset);
    idx = snap_coord(px, regs.sort_origin, regs.sort_step);
    if (slot < 0 || slot >= longint'(usable_len())) return STATUS_DROP;
    if (idx < 0) idx = 0;
    if (idx > 65535) idx = 65535;
    s = int'(slot);
    line_val[s] = 24'(idx << FRAC);
    line_set[s] = 1'b1;
    if (!have_point || s < first_pt) first_pt = s;
    if (!have_point || s > last_pt) last_pt = s;
    have_point = 1'b1;
    return STATUS_OK;
  endfunction

  function automatic logic [1:0] line_build();
    int unsigned n, lo, hi, beg;
    longint unsigned g, a, b, k;
    n = usable_len();
    if (!have_point || first_pt >= n || !line_set[first_pt]) return STATUS_EMPTY;
    lo = first_pt;
    hi = (last_pt < n) ? last_pt : n - 1;
    while (hi > lo && !line_set[hi]) hi--;
    beg = lo;
    for (int unsigned i = lo + 1; i <= hi; i++) begin
      if (line_set[i]) begin
        g = i - beg;
        a = line_val[beg];
        b = line_val[i];
        for (int unsigned j = beg + 1; j < i; j++) begin
          k = j - beg;
          line_val[j] = 24'((a * (g - k) + b * k + g / 2) / g);
        end
        beg = i;
      end
    end
    for (int unsigned i = 0; i < lo; i++) line_val[i] = line_val[lo];
    for (int unsigned i = hi + 1; i < n; i++) line_val[i] = line_val[hi];
    for (int unsigned i = 0; i < n; i++) line_set[i] = 1'b1;
    first_pt = 0;
    last_pt = n - 1;
    return STATUS_OK;
  endfunction

  function automatic out_item_t predict_sample(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.func)
      FUNC_CLEAR: line_clear();
      FUNC_ADD: begin
        r.status = line_add_point(it.point_x, it.point_y);
        n_points++;
        if (r.status == STATUS_DROP) n_drops++;
      end
      FUNC_BUILD: begin
        r.status = line_build();
        n_builds++;
      end
      default: begin
        n_reads++;
        if (line_set[it.read_index]) begin
          r.sample_value = line_val[it.read_index];
          r.sample_set = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Sender: called at a rising edge, returns at the edge that accepts the item.
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_samples.push_back(predict_sample(it));
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SINGLE_ORIGIN: regs.single_origin = data;
      CFG_SINGLE_STEP:   regs.single_step = data[30:0];
      CFG_SORT_ORIGIN:   regs.sort_origin = data;
      CFG_SORT_STEP:     regs.sort_step = data[30:0];
      CFG_SLOT_OFFSET:   regs.slot_offset = data[15:0];
      CFG_LINE_LENGTH:   regs.line_length = data[10:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] so, logic [31:0] ss, logic [31:0] xo, logic [31:0] xs,
                           logic [31:0] off, logic [31:0] len);
    drain();
    write_reg(CFG_SINGLE_ORIGIN, so);
    write_reg(CFG_SINGLE_STEP, ss);
    write_reg(CFG_SORT_ORIGIN, xo);
    write_reg(CFG_SORT_STEP, xs);
    write_reg(CFG_SLOT_OFFSET, off);
    write_reg(CFG_LINE_LENGTH, len);
  endtask

  task automatic send_op(logic [1:0] f, logic [31:0] x, logic [31:0] y, logic [9:0] ri);
    in_item_t it;
    it.func = f;
    it.point_x = x;
    it.point_y = y;
    it.read_index = ri;
    send_item(it);
  endtask

  // Coordinate that snaps near a chosen slot under the given origin and step.
  function automatic logic [31:0] aim(logic [31:0] o, logic [30:0] st, longint slot_no);
    longint s;
    s = (st == 0) ? 64'sd1 : longint'({33'b0, st});
    return 32'(longint'($signed(o)) + slot_no * s
               + longint'($urandom_range(0, 9999)) * s / 10000);
  endfunction

  task automatic add_slot(longint slot, longint idx);
    send_op(FUNC_ADD, aim(regs.sort_origin, regs.sort_step, idx),
            aim(regs.single_origin, regs.single_step, slot + regs.slot_offset), '0);
  endtask

  task automatic test_reset_reads();
    send_op(FUNC_READ, '0, '0, 10'd0);
    send_op(FUNC_READ, '0, '0, 10'd1023);
    send_op(FUNC_BUILD, '0, '0, '0);
  endtask

  task automatic test_directed_points();
    send_op(FUNC_ADD, 32'h7fff_ffff, 32'h0000_0000, '0);
    send_op(FUNC_ADD, 32'h8000_0000, 32'(1023 << 16), '0);
    send_op(FUNC_ADD, 32'h0000_8000, 32'hffff_0000, '0);
    send_op(FUNC_ADD, 32'hffff_8000, 32'(1024 << 16), '0);
    send_op(FUNC_ADD, 32'h0000_8001, 32'h0000_7fff, '0);
    send_op(FUNC_ADD, 32'h0064_0000, 32'(300 << 16), '0);
    send_op(FUNC_ADD, 32'h0001_0000, 32'(300 << 16), '0);
    send_op(FUNC_ADD, 32'h0fff_0000, 32'(303 << 16), '0);
    send_op(FUNC_BUILD, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd0);
    send_op(FUNC_READ, '0, '0, 10'd301);
    send_op(FUNC_READ, '0, '0, 10'd302);
    send_op(FUNC_READ, '0, '0, 10'd1023);
    send_op(FUNC_ADD, 32'h0002_0000, 32'(10 << 16), '0);
    send_op(FUNC_BUILD, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd5);
    send_op(FUNC_CLEAR, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd5);
    send_op(FUNC_BUILD, '0, '0, '0);
  endtask

  task automatic test_config_extremes();
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'hffff, 32'h0);
    send_op(FUNC_CLEAR, '0, '0, '0);
    send_op(FUNC_ADD, 32'h1234_5678, 32'h8000_0000, '0);
    send_op(FUNC_BUILD, '0, '0, '0);
    write_all(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7ff);
    send_op(FUNC_ADD, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_op(FUNC_ADD, 32'h0, 32'h7fff_ffff, '0);
    send_op(FUNC_BUILD, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd0);
    write_all(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'd1);
    send_op(FUNC_CLEAR, '0, '0, '0);
    add_slot(0, 77);
    add_slot(1, 5);
    send_op(FUNC_BUILD, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd0);
    write_all(32'h0, 32'h10000, 32'h0, 32'h10000, 32'd3, 32'd64);
    send_op(FUNC_CLEAR, '0, '0, '0);
    add_slot(10, 100);
    add_slot(40, 900);
    drain();
    write_reg(CFG_LINE_LENGTH, 32'd20);
    send_op(FUNC_BUILD, '0, '0, '0);
    send_op(FUNC_READ, '0, '0, 10'd19);
    send_op(FUNC_CLEAR, '0, '0, '0);
    add_slot(10, 4);
    drain();
    write_reg(CFG_LINE_LENGTH, 32'd5);
    send_op(FUNC_BUILD, '0, '0, '0);
  endtask

  task automatic random_config();
    if ($urandom_range(9) < 2) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      write_all(32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                $urandom_range(1 << 8, 1 << 20),
                32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                $urandom_range(1, 1 << 18),
                $urandom_range(0, 8),
                ($urandom_range(9) == 0) ? 1024 : $urandom_range(2, 64));
    end
  endtask

  task automatic test_random_lines(int target);
    int len;
    in_item_t it;
    while (sent_items < target) begin
      random_config();
      quiet = ($urandom_range(5) == 0);
      for (int seq = 0; seq < 6 && sent_items < target; seq++) begin
        len = usable_len();
        if ($urandom_range(99) < 85) send_op(FUNC_CLEAR, $urandom, $urandom, 10'($urandom));
        repeat ($urandom_range(1, 10))
          add_slot($signed($urandom_range(0, len + 3)) - 2, $urandom_range(0, 70000));
        if ($urandom_range(99) < 15) begin
          it = in_item_t'({$urandom, $urandom, $urandom});
          send_item(it);
        end
        send_op(FUNC_BUILD, $urandom, $urandom, 10'($urandom));
        repeat ($urandom_range(2, 8))
          send_op(FUNC_READ, $urandom, $urandom, 10'($urandom_range(0, len + 2)));
        if ($urandom_range(3) == 0) add_slot($urandom_range(0, len), $urandom_range(0, 65535));
        if ($urandom_range(3) == 0) send_op(FUNC_READ, $urandom, $urandom, 10'($urandom));
      end
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_all(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'd32);
    quiet = 1'b1;
    hold_cycles = 400;
    repeat (20) send_op(FUNC_READ, '0, '0, 10'($urandom_range(0, 40)));
    quiet = 1'b0;
  endtask

  // Receiver: random stall, plus a long hold when requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 37);
    end
  end

  always @(negedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", out_item);
      end else begin
        exp_r = pending_samples.pop_front();
        if (out_item.sample_value !== exp_r.sample_value ||
            out_item.sample_set !== exp_r.sample_set || out_item.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h set %b status %0d, got value %h set %b status %0d",
                     exp_r.sample_value, exp_r.sample_set, exp_r.status,
                     out_item.sample_value, out_item.sample_set, out_item.status);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    out_stall <= 1'b0;
    regs = '{single_origin: 0, single_step: 31'd65536, sort_origin: 0,
             sort_step: 31'd65536, slot_offset: 0, line_length: 11'd1024};
    foreach (line_val[i]) line_val[i] = '0;
    line_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_reads();
    test_directed_points();
    test_config_extremes();
    test_backpressure();
    test_random_lines(600);
    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d items: %0d point adds (%0d dropped), %0d builds, %0d reads.",
             sent_items, n_points, n_drops, n_builds, n_reads);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("Mismatch count: %0d", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
